// ===== rtl/accel_tilt_pitch_roll_filter_core_assert.svh =====
// Assertion macros for the tilt filter core.
// Used by the top level; no other dependencies.
`ifndef ACCEL_TILT_PITCH_ROLL_FILTER_CORE_ASSERT_SVH
`define ACCEL_TILT_PITCH_ROLL_FILTER_CORE_ASSERT_SVH

// property that holds in the cycle after the antecedent
`define ATP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

// property that holds at the same edge
`define ATP_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

`endif

// ===== rtl/atprf_pkg.sv =====
// Shared constants and types for the tilt filter core.
// No dependencies.
package atprf_pkg;
  localparam int SAMPLE_BITS_DEF = 16;
  localparam int ANGLE_BITS_DEF  = 16;
  localparam int NITER           = 24;
  localparam int ITER_BITS       = 5;
  localparam int DW              = 64;
  localparam logic [20:0] GAIN_Q20 = 21'd1726753;
  localparam logic [15:0] BLEND_RESET = 16'd3277;

  // configuration register indexes
  localparam logic CFG_BLEND = 1'b0;
  localparam logic CFG_MOUNT = 1'b1;

  // CORDIC command to the shared unit
  localparam logic OP_ROT = 1'b0;
  localparam logic OP_VEC = 1'b1;

  typedef struct packed {
    logic             start;
    logic             op;
    logic signed [DW-1:0] x;
    logic signed [DW-1:0] y;
    logic [31:0]      ang;
  } cordic_req_t;

  typedef struct packed {
    logic             done;
    logic signed [DW-1:0] x;
    logic signed [DW-1:0] y;
    logic [31:0]      ang;
  } cordic_rsp_t;

  function automatic logic [31:0] atan_lut(input logic [ITER_BITS-1:0] i);
    logic [31:0] v;
    case (i)
      5'd0:  v = 32'h20000000;  5'd1:  v = 32'h12E4051E;
      5'd2:  v = 32'h09FB385B;  5'd3:  v = 32'h051111D4;
      5'd4:  v = 32'h028B0D43;  5'd5:  v = 32'h0145D7E1;
      5'd6:  v = 32'h00A2F61E;  5'd7:  v = 32'h00517C55;
      5'd8:  v = 32'h0028BE53;  5'd9:  v = 32'h00145F2F;
      5'd10: v = 32'h000A2F98;  5'd11: v = 32'h000517CC;
      5'd12: v = 32'h00028BE6;  5'd13: v = 32'h000145F3;
      5'd14: v = 32'h0000A2FA;  5'd15: v = 32'h0000517D;
      5'd16: v = 32'h000028BE;  5'd17: v = 32'h0000145F;
      5'd18: v = 32'h00000A30;  5'd19: v = 32'h00000518;
      5'd20: v = 32'h0000028C;  5'd21: v = 32'h00000146;
      5'd22: v = 32'h000000A3;  5'd23: v = 32'h00000051;
      default: v = 32'h0;
    endcase
    return v;
  endfunction
endpackage

// ===== rtl/atprf_cordic.sv =====
// Shared iterative CORDIC unit: rotate or vector, one iteration per cycle.
// Depends on atprf_pkg.
module atprf_cordic
  import atprf_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  cordic_req_t req,
  output cordic_rsp_t rsp
);
  logic signed [DW-1:0] x_r, x_nxt, y_r, y_nxt;
  logic [31:0] r_r, r_nxt;
  logic [ITER_BITS-1:0] it_r, it_nxt;
  logic busy_r, busy_nxt, op_r, op_nxt, done_r, done_nxt;
  logic signed [DW-1:0] dx, dy;
  logic [31:0] at, pre_a;
  logic dir;

  assign at = atan_lut(it_r);
  assign dx = y_r >>> it_r;
  assign dy = x_r >>> it_r;
  // rotate: drive residual angle to zero; vector: drive y to zero
  assign dir = (op_r == OP_ROT) ? !r_r[31] : (y_r > 0);

  always_comb begin
    x_nxt = x_r; y_nxt = y_r; r_nxt = r_r; it_nxt = it_r;
    busy_nxt = busy_r; op_nxt = op_r; done_nxt = 1'b0;
    pre_a = req.ang + 32'h40000000;
    if (req.start) begin
      op_nxt = req.op; it_nxt = '0; busy_nxt = 1'b1;
      x_nxt = req.x; y_nxt = req.y; r_nxt = req.ang;
      if (req.op == OP_ROT) begin
        if (pre_a[31]) begin
          x_nxt = -req.x; y_nxt = -req.y; r_nxt = req.ang + 32'h80000000;
        end
      end else begin
        r_nxt = '0;
        if (req.x == 0 && req.y == 0) begin
          busy_nxt = 1'b0; done_nxt = 1'b1; x_nxt = '0;
        end else if (req.x < 0) begin
          x_nxt = -req.x; y_nxt = -req.y; r_nxt = 32'h80000000;
        end
      end
    end else if (busy_r) begin
      if (dir) begin
        x_nxt = x_r - dx; y_nxt = y_r + dy;
      end else begin
        x_nxt = x_r + dx; y_nxt = y_r - dy;
      end
      if (op_r == OP_VEC) begin
        x_nxt = dir ? x_r + dx : x_r - dx;
        y_nxt = dir ? y_r - dy : y_r + dy;
        r_nxt = dir ? r_r + at : r_r - at;
      end else begin
        r_nxt = dir ? r_r - at : r_r + at;
      end
      it_nxt = it_r + 1'b1;
      if (it_r == ITER_BITS'(NITER - 1)) begin
        busy_nxt = 1'b0; done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0; done_r <= 1'b0; it_r <= '0; op_r <= OP_ROT;
    end else begin
      busy_r <= busy_nxt; done_r <= done_nxt; it_r <= it_nxt; op_r <= op_nxt;
    end
    x_r <= x_nxt; y_r <= y_nxt; r_r <= r_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.x    = x_r;
  assign rsp.y    = y_r;
  assign rsp.ang  = r_r;
endmodule

// ===== rtl/accel_tilt_pitch_roll_filter_core.sv =====
// Top level of the tilt filter: sequencer, multiplier and state registers.
// Depends on atprf_pkg, atprf_cordic and the assertion macro header.
// An accepted word runs through 9 CORDIC passes on the single shared unit before
// out_tvalid; a zero-vector vectoring pass finishes without iterating.
// One word at a time: in_tready is low while a word is in work.
// Reset (synchronous, rst_n low): registers to defaults, angle state zero.
module accel_tilt_pitch_roll_filter_core
  import atprf_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int ANGLE_BITS  = ANGLE_BITS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  // accel_x, accel_y, accel_z from bit 0 up, zero filled to bytes
  input  logic [((3*SAMPLE_BITS+7)/8)*8-1:0] in_tdata,
  output logic out_tvalid,
  input  logic out_tready,
  // pitch_angle, roll_angle from bit 0 up, zero filled to bytes
  output logic [((2*ANGLE_BITS+7)/8)*8-1:0] out_tdata,
  input  logic cfg_we,
  input  logic cfg_index,
  input  logic [((ANGLE_BITS > 16) ? ANGLE_BITS : 16)-1:0] cfg_wdata
);
  localparam int OW = ((2*ANGLE_BITS+7)/8)*8;
  localparam int SH = 40 - SAMPLE_BITS;
  localparam int AS = 32 - ANGLE_BITS;

  localparam logic [3:0] S_IDLE = 4'd0, S_MROT = 4'd1, S_MUL1 = 4'd2,
    S_RVEC = 4'd3, S_MUL2 = 4'd4, S_PVEC = 4'd5, S_B1 = 4'd6, S_B2 = 4'd7,
    S_B3 = 4'd8, S_OUT = 4'd9;

  logic [3:0] st_r, st_nxt;
  logic [1:0] bsel_r, bsel_nxt; // 0 pitch, 1 roll
  logic launch_r, launch_nxt;
  logic [15:0] weight_r;
  logic [ANGLE_BITS-1:0] mount_r, pitch_r, roll_r, pitch_nxt, roll_nxt;
  logic signed [DW-1:0] zk_r, zk_nxt, yf_r, yf_nxt, mag_r, mag_nxt;
  logic signed [DW-1:0] bx_r, bx_nxt, by_r, by_nxt;
  logic [31:0] nroll_r, nroll_nxt, npitch_r, npitch_nxt;
  logic out_v_r, out_v_nxt;
  logic [OW-1:0] out_d_r, out_d_nxt;
  cordic_req_t req;
  cordic_rsp_t rsp;
  logic signed [DW-1:0] mul_a, mul_p;
  logic signed [DW-1:0] sx, sy, sz;
  logic [31:0] old_a, new_a, fin;

  atprf_cordic u_cordic (.clk(clk), .rst_n(rst_n), .req(req), .rsp(rsp));

  assign sx = DW'($signed(in_tdata[SAMPLE_BITS-1:0])) <<< SH;
  assign sy = DW'($signed(in_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS])) <<< SH;
  assign sz = DW'($signed(in_tdata[3*SAMPLE_BITS-1:2*SAMPLE_BITS])) <<< SH;

  // gain compensation multiply; operand is below 2^41 in magnitude
  assign mul_p = (mul_a * $signed({1'b0, GAIN_Q20})) >>> 20;
  assign in_tready = (st_r == S_IDLE);
  assign fin = rsp.ang + (32'd1 << (31 - ANGLE_BITS));

  always_comb begin
    mul_a = (st_r == S_MUL1) ? zk_r : yf_r;
    old_a = (bsel_r == 2'd0) ? {pitch_r, AS'(0)} : {roll_r, AS'(0)};
    new_a = (bsel_r == 2'd0) ? npitch_r : nroll_r;
  end

  always_comb begin
    st_nxt = st_r; bsel_nxt = bsel_r; launch_nxt = 1'b0;
    zk_nxt = zk_r; yf_nxt = yf_r; mag_nxt = mag_r; bx_nxt = bx_r; by_nxt = by_r;
    nroll_nxt = nroll_r; npitch_nxt = npitch_r;
    pitch_nxt = pitch_r; roll_nxt = roll_r;
    out_v_nxt = out_v_r && !out_tready; out_d_nxt = out_d_r;
    req = '0;
    case (st_r)
      S_IDLE: begin
        if (in_tvalid) begin
          req.start = 1'b1; req.op = OP_ROT; req.x = sx; req.y = sy;
          req.ang = {mount_r, AS'(0)};
          zk_nxt = sz; st_nxt = S_MROT;
        end
      end
      S_MROT: if (rsp.done) begin
        yf_nxt = rsp.y; mag_nxt = rsp.x; st_nxt = S_MUL1;
      end
      S_MUL1: begin
        req.start = 1'b1; req.op = OP_VEC; req.x = mul_p; req.y = mag_r;
        st_nxt = S_RVEC;
      end
      S_RVEC: if (rsp.done) begin
        nroll_nxt = 32'd0 - rsp.ang; mag_nxt = rsp.x; st_nxt = S_MUL2;
      end
      S_MUL2: begin
        req.start = 1'b1; req.op = OP_VEC; req.x = mag_r; req.y = mul_p;
        st_nxt = S_PVEC;
      end
      S_PVEC: if (rsp.done) begin
        npitch_nxt = rsp.ang; bsel_nxt = 2'd0; st_nxt = S_B1; launch_nxt = 1'b1;
      end
      S_B1: begin
        if (launch_r) begin
          req.start = 1'b1; req.op = OP_ROT; req.ang = new_a;
          req.x = DW'({1'b0, weight_r}) <<< 20;
        end else if (rsp.done) begin
          bx_nxt = rsp.x; by_nxt = rsp.y; st_nxt = S_B2; launch_nxt = 1'b1;
        end
      end
      S_B2: begin
        if (launch_r) begin
          req.start = 1'b1; req.op = OP_ROT; req.ang = old_a;
          req.x = (DW'(65536) - DW'({1'b0, weight_r})) <<< 20;
        end else if (rsp.done) begin
          bx_nxt = bx_r + rsp.x; by_nxt = by_r + rsp.y;
          st_nxt = S_B3; launch_nxt = 1'b1;
        end
      end
      S_B3: begin
        if (launch_r) begin
          req.start = 1'b1; req.op = OP_VEC; req.x = bx_r; req.y = by_r;
        end else if (rsp.done) begin
          if (bsel_r == 2'd0) begin
            pitch_nxt = fin[31:AS]; bsel_nxt = 2'd1;
            st_nxt = S_B1; launch_nxt = 1'b1;
          end else begin
            roll_nxt = fin[31:AS]; st_nxt = S_OUT;
          end
        end
      end
      S_OUT: begin
        if (!out_v_r || out_tready) begin
          out_v_nxt = 1'b1;
          out_d_nxt = OW'({roll_r, pitch_r});
          st_nxt = S_IDLE;
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; bsel_r <= 2'd0; launch_r <= 1'b0; out_v_r <= 1'b0;
      weight_r <= BLEND_RESET;
      mount_r <= ANGLE_BITS'((1 << ANGLE_BITS) / 12);
      pitch_r <= '0; roll_r <= '0;
    end else begin
      st_r <= st_nxt; bsel_r <= bsel_nxt; launch_r <= launch_nxt;
      out_v_r <= out_v_nxt; pitch_r <= pitch_nxt; roll_r <= roll_nxt;
      if (cfg_we) begin
        if (cfg_index == CFG_BLEND) weight_r <= 16'(cfg_wdata);
        else mount_r <= ANGLE_BITS'(cfg_wdata);
      end
    end
    zk_r <= zk_nxt; yf_r <= yf_nxt; mag_r <= mag_nxt; bx_r <= bx_nxt;
    by_r <= by_nxt; nroll_r <= nroll_nxt; npitch_r <= npitch_nxt;
    out_d_r <= out_d_nxt;
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_d_r;

`include "accel_tilt_pitch_roll_filter_core_assert.svh"
  `ATP_ASSERT_SAME(a_busy_not_ready, st_r != S_IDLE, !in_tready)
  `ATP_ASSERT_NEXT(a_accept_starts, in_tvalid && in_tready, st_r == S_MROT)
  `ATP_ASSERT_NEXT(a_out_sets_valid, st_r == S_OUT && (!out_v_r || out_tready),
    out_tvalid)
endmodule
